// ===== hdl/meter_time_string_to_epoch_macros.svh =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: assertion macros
// Clocked assertion shorthands for the port checker of this block.
// ----------------------------------------------------------------------------
`ifndef METER_TIME_STRING_TO_EPOCH_MACROS_SVH
`define METER_TIME_STRING_TO_EPOCH_MACROS_SVH

// Check a property on every rising edge outside reset.
`define MTSE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mtse assertion failed");

// Check a property on every rising edge, reset included.
`define MTSE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("mtse assertion failed");

`endif

// ===== hdl/mtse_pkg.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: package
// Transaction types, pipeline stage types, constants and the month table.
// ----------------------------------------------------------------------------
package mtse_pkg;

  localparam int unsigned OffW    = 17;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgWinter = 1'b0,
    CfgSummer = 1'b1
  } cfg_idx_e;

  localparam logic [OffW-1:0] WinterReset = 17'd3600;
  localparam logic [OffW-1:0] SummerReset = 17'd7200;

  localparam logic [7:0] CharWinter = 8'h57;
  localparam logic [7:0] CharSummer = 8'h53;
  localparam logic [7:0] DigitLo    = 8'h30;
  localparam logic [7:0] DigitHi    = 8'h39;

  localparam logic [3:0] PosSuffix = 4'd12;

  localparam logic [2:0] SlotYear   = 3'd0;
  localparam logic [2:0] SlotMonth  = 3'd1;
  localparam logic [2:0] SlotDay    = 3'd2;
  localparam logic [2:0] SlotHour   = 3'd3;
  localparam logic [2:0] SlotMinute = 3'd4;
  localparam logic [2:0] SlotSecond = 3'd5;

  localparam logic [6:0] MonthMin = 7'd1;
  localparam logic [6:0] MonthMax = 7'd12;

  // days from 1970-01-01 to 2000-01-01, less one for the day-of-month base
  localparam logic [15:0] DaysTo2000M1 = 16'd10956;
  localparam logic [16:0] SecPerDay    = 17'd86400;
  localparam logic [9:0]  SecPerQuarter = 10'd900;
  // floor(2^32 / 225): quotient estimate short by at most one
  localparam logic [24:0] Recip225     = 25'd19088743;

  typedef struct packed {
    logic [7:0] character;
    logic       start_req;
  } in_t;

  typedef struct packed {
    logic [31:0] epoch_seconds;
    logic [1:0]  quarter_index;
    logic [31:0] quarter_start;
    logic        format_error;
  } out_t;

  typedef struct packed {
    logic [6:0] year;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
  } fields_t;

  typedef struct packed {
    fields_t         fld;
    logic [OffW-1:0] off;
    logic            err;
  } stg_a_t;

  typedef struct packed {
    logic [15:0]     days;
    logic [18:0]     sod;
    logic [OffW-1:0] off;
    logic            err;
  } stg_b_t;

  typedef struct packed {
    logic [31:0] t;
    logic        err;
  } stg_c_t;

  typedef struct packed {
    logic [31:0] t;
    logic [22:0] qe;
    logic        err;
  } stg_d_t;

  typedef struct packed {
    logic [31:0] t;
    logic [22:0] qe;
    logic [31:0] p;
    logic        err;
  } stg_e_t;

  function automatic logic [8:0] days_before_month(input logic [6:0] month);
    logic [8:0] d;
    case (month)
      7'd1:    d = 9'd0;
      7'd2:    d = 9'd31;
      7'd3:    d = 9'd59;
      7'd4:    d = 9'd90;
      7'd5:    d = 9'd120;
      7'd6:    d = 9'd151;
      7'd7:    d = 9'd181;
      7'd8:    d = 9'd212;
      7'd9:    d = 9'd243;
      7'd10:   d = 9'd273;
      7'd11:   d = 9'd304;
      7'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// ===== hdl/meter_time_string_to_epoch.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: top level
// Converts a 13-character meter time string into Unix epoch seconds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_i/in_stall_o) carries one ASCII character
//   per transaction; start_req marks character 0 of a new string. The
//   thirteenth character (suffix W, S or other) yields one result on the
//   output channel (out_valid_o/out_o/out_stall_i); other characters give none.
//   Throughput: one character per cycle while in_stall_o stays low. The stage pitch is set by
//   one multiplier per stage: the day-count by 86400 product and the 30 x 25
//   bit reciprocal multiply of the divide by 900.
//   Pipeline: the accepted suffix passes six registered stages before the result
//   is valid (parser, two epoch stages, three quarter-split stages incl. output reg).
//   Configuration: cfg_we_i writes winter (index 0) or summer (index 1)
//   offset from cfg_wdata_i; write only while idle.
//   Reset: position and error flag cleared, offsets return to 3600 and 7200,
//   pipeline emptied. Field registers hold no reset value.
//   Stall: a stalled result holds; the pipeline keeps filling until a stage
//   holding the suffix transaction backs up into the parser, then
//   in_stall_o rises.
// ----------------------------------------------------------------------------
module meter_time_string_to_epoch (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  mtse_pkg::in_t                 in_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output mtse_pkg::out_t                out_o,
  input  logic                          out_stall_i,
  input  logic                          cfg_we_i,
  input  logic [mtse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mtse_pkg::OffW-1:0]     cfg_wdata_i
);

  logic             a_valid, a_stall;
  mtse_pkg::stg_a_t a_data;
  logic             c_valid, c_stall;
  mtse_pkg::stg_c_t c_data;

  mtse_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .a_valid_o   (a_valid),
    .a_o         (a_data),
    .a_stall_i   (a_stall)
  );

  mtse_calc u_calc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .a_valid_i (a_valid),
    .a_i       (a_data),
    .a_stall_o (a_stall),
    .c_valid_o (c_valid),
    .c_o       (c_data),
    .c_stall_i (c_stall)
  );

  mtse_quart u_quart (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .c_valid_i   (c_valid),
    .c_i         (c_data),
    .c_stall_o   (c_stall),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== hdl/mtse_parse.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: character parser
// Builds the two-digit fields, tracks format errors, holds the offset
// registers and launches one pipeline transaction per suffix character.
// ----------------------------------------------------------------------------
module mtse_parse (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  mtse_pkg::in_t                 in_i,
  output logic                          in_stall_o,
  input  logic                          cfg_we_i,
  input  logic [mtse_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [mtse_pkg::OffW-1:0]     cfg_wdata_i,
  output logic                          a_valid_o,
  output mtse_pkg::stg_a_t              a_o,
  input  logic                          a_stall_i
);

  logic [3:0]                  pos_q, pos_d;
  logic [3:0]                  pend_q, pend_d;
  logic                        err_q, err_d;
  logic [6:0]                  fld_q [6];
  logic                        fld_we;
  logic [2:0]                  fld_idx;
  logic [6:0]                  fld_val;
  logic [mtse_pkg::OffW-1:0]   winter_q, summer_q;
  logic                        a_v_q, a_v_d;
  mtse_pkg::stg_a_t            a_q, a_d;
  logic                        accept;
  logic                        is_suffix;

  assign in_stall_o = a_v_q && a_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    logic [3:0] pos_e;
    logic       err_e;
    logic       is_dig;
    logic [3:0] dig;
    pos_e   = in_i.start_req ? 4'd0 : pos_q;
    err_e   = in_i.start_req ? 1'b0 : err_q;
    is_dig  = in_i.character inside {[mtse_pkg::DigitLo:mtse_pkg::DigitHi]};
    dig     = is_dig ? in_i.character[3:0] : 4'd0;
    is_suffix = (pos_e >= mtse_pkg::PosSuffix);
    pos_d   = pos_q;
    pend_d  = pend_q;
    err_d   = err_q;
    fld_we  = 1'b0;
    fld_idx = pos_e[3:1];
    fld_val = 7'(pend_q) * 7'd10 + 7'(dig);

    a_d.fld.year   = fld_q[mtse_pkg::SlotYear];
    a_d.fld.month  = fld_q[mtse_pkg::SlotMonth];
    a_d.fld.day    = fld_q[mtse_pkg::SlotDay];
    a_d.fld.hour   = fld_q[mtse_pkg::SlotHour];
    a_d.fld.minute = fld_q[mtse_pkg::SlotMinute];
    a_d.fld.second = fld_q[mtse_pkg::SlotSecond];
    a_d.err        = err_e;
    if (in_i.character == mtse_pkg::CharWinter) begin
      a_d.off = winter_q;
    end else if (in_i.character == mtse_pkg::CharSummer) begin
      a_d.off = summer_q;
    end else begin
      a_d.off = '0;
    end

    if (accept) begin
      if (!is_suffix) begin
        err_d = err_e || !is_dig;
        if (!pos_e[0]) begin
          pend_d = dig;
        end else begin
          fld_we = 1'b1;
          if (fld_idx == mtse_pkg::SlotMonth &&
              (fld_val < mtse_pkg::MonthMin || fld_val > mtse_pkg::MonthMax)) begin
            err_d = 1'b1;
          end
        end
        pos_d = pos_e + 4'd1;
      end else begin
        // end of string: start over with the next character
        pos_d = '0;
        err_d = 1'b0;
      end
    end

    // stage A only moves when it is empty or draining
    a_v_d = a_v_q;
    if (!in_stall_o) begin
      a_v_d = accept && is_suffix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      pend_q   <= '0;
      err_q    <= 1'b0;
      a_v_q    <= 1'b0;
      winter_q <= mtse_pkg::WinterReset;
      summer_q <= mtse_pkg::SummerReset;
    end else begin
      pos_q  <= pos_d;
      pend_q <= pend_d;
      err_q  <= err_d;
      a_v_q  <= a_v_d;
      if (cfg_we_i) begin
        case (mtse_pkg::cfg_idx_e'(cfg_idx_i))
          mtse_pkg::CfgWinter: winter_q <= cfg_wdata_i;
          mtse_pkg::CfgSummer: summer_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fld_we) begin
      fld_q[fld_idx] <= fld_val;
    end
    if (accept && is_suffix && !in_stall_o) begin
      a_q <= a_d;
    end
  end

  assign a_valid_o = a_v_q;
  assign a_o       = a_q;

endmodule

// ===== hdl/mtse_calc.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: epoch arithmetic
// Stage B forms day count and second of day, stage C the offset epoch.
// ----------------------------------------------------------------------------
module mtse_calc (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             a_valid_i,
  input  mtse_pkg::stg_a_t a_i,
  output logic             a_stall_o,
  output logic             c_valid_o,
  output mtse_pkg::stg_c_t c_o,
  input  logic             c_stall_i
);

  logic             b_v_q, c_v_q;
  logic             b_stall, c_stall;
  mtse_pkg::stg_b_t b_q, b_d;
  mtse_pkg::stg_c_t c_q, c_d;

  assign c_stall   = c_v_q && c_stall_i;
  assign b_stall   = b_v_q && c_stall;
  assign a_stall_o = b_stall;

  always_comb begin
    logic [7:0]  yy3;
    logic        leap_adj;
    yy3      = {1'b0, a_i.fld.year} + 8'd3;
    // 2000 to 2099: every fourth year is a leap year
    leap_adj = (a_i.fld.month > 7'd2) && (a_i.fld.year[1:0] == 2'd0);
    b_d.days = mtse_pkg::DaysTo2000M1
             + 16'(a_i.fld.year) * 16'd365
             + 16'(yy3[7:2])
             + 16'(mtse_pkg::days_before_month(a_i.fld.month))
             + 16'(leap_adj)
             + 16'(a_i.fld.day);
    b_d.sod  = 19'(a_i.fld.hour) * 19'd3600
             + 19'(a_i.fld.minute) * 19'd60
             + 19'(a_i.fld.second);
    b_d.off  = a_i.off;
    b_d.err  = a_i.err;
  end

  always_comb begin
    c_d.t   = 32'(b_q.days) * 32'(mtse_pkg::SecPerDay) + 32'(b_q.sod) - 32'(b_q.off);
    c_d.err = b_q.err;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else begin
      if (!b_stall) begin
        b_v_q <= a_valid_i;
      end
      if (!c_stall) begin
        c_v_q <= b_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_i && !b_stall) begin
      b_q <= b_d;
    end
    if (b_v_q && !c_stall) begin
      c_q <= c_d;
    end
  end

  assign c_valid_o = c_v_q;
  assign c_o       = c_q;

endmodule

// ===== hdl/mtse_quart.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: quarter-hour split
// Divides the epoch by 900 with a reciprocal multiply and one correction
// step, then registers the result transaction.
// ----------------------------------------------------------------------------
module mtse_quart (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             c_valid_i,
  input  mtse_pkg::stg_c_t c_i,
  output logic             c_stall_o,
  output logic             out_valid_o,
  output mtse_pkg::out_t   out_o,
  input  logic             out_stall_i
);

  logic             d_v_q, e_v_q, f_v_q;
  logic             d_stall, e_stall, f_stall;
  mtse_pkg::stg_d_t d_q, d_d;
  mtse_pkg::stg_e_t e_q, e_d;
  mtse_pkg::out_t   f_q, f_d;
  logic [54:0]      prod;

  assign f_stall   = f_v_q && out_stall_i;
  assign e_stall   = e_v_q && f_stall;
  assign d_stall   = d_v_q && e_stall;
  assign c_stall_o = d_stall;

  // floor(t/900) = floor(floor(t/4)/225)
  assign prod = 55'(c_i.t[31:2]) * 55'(mtse_pkg::Recip225);

  always_comb begin
    d_d.t   = c_i.t;
    d_d.qe  = prod[54:32];
    d_d.err = c_i.err;
  end

  always_comb begin
    e_d.t   = d_q.t;
    e_d.qe  = d_q.qe;
    e_d.p   = 32'(d_q.qe) * 32'(mtse_pkg::SecPerQuarter);
    e_d.err = d_q.err;
  end

  always_comb begin
    logic [31:0] rem;
    logic        fix;
    rem = e_q.t - e_q.p;
    // estimate is short by at most one quarter
    fix = (rem[10:0] >= 11'(mtse_pkg::SecPerQuarter));
    if (e_q.err) begin
      f_d = '0;
      f_d.format_error = 1'b1;
    end else begin
      f_d.epoch_seconds = e_q.t;
      f_d.quarter_index = e_q.qe[1:0] + 2'(fix);
      f_d.quarter_start = e_q.p + (fix ? 32'(mtse_pkg::SecPerQuarter) : 32'd0);
      f_d.format_error  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else begin
      if (!d_stall) begin
        d_v_q <= c_valid_i;
      end
      if (!e_stall) begin
        e_v_q <= d_v_q;
      end
      if (!f_stall) begin
        f_v_q <= e_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_i && !d_stall) begin
      d_q <= d_d;
    end
    if (d_v_q && !e_stall) begin
      e_q <= e_d;
    end
    if (e_v_q && !f_stall) begin
      f_q <= f_d;
    end
  end

  assign out_valid_o = f_v_q;
  assign out_o       = f_q;

endmodule

// ===== hdl/mtse_checker.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: port checker
// Watches the top-level result channel and checks result consistency.
// ----------------------------------------------------------------------------
`include "meter_time_string_to_epoch_macros.svh"

module mtse_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input mtse_pkg::out_t out_o,
  input logic           out_stall_i
);

  logic [31:0] span;

  assign span = out_o.epoch_seconds - out_o.quarter_start;

  // error results carry no time
  `MTSE_ASSERT(a_err_zero, out_valid_o && out_o.format_error |-> out_o.epoch_seconds == 32'd0 && out_o.quarter_start == 32'd0 && out_o.quarter_index == 2'd0)

  // quarter start lies within the 900 s below the epoch
  `MTSE_ASSERT(a_quarter_span, out_valid_o && !out_o.format_error |-> span < 32'd900)

  // hold a stalled result transaction
  `MTSE_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_o))

  // no result in the cycle after a reset edge
  `MTSE_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid_o)

endmodule

bind meter_time_string_to_epoch mtse_checker u_mtse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_o       (out_o),
  .out_stall_i (out_stall_i)
);

// ===== sim/meter_time_string_to_epoch_checker.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: result checker
// Follows every character and offset write the block takes, works out the
// epoch result of each completed string and compares it field by field with
// the results that leave the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meter_time_string_to_epoch_checker
  import mtse_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  in_t                 in_i,
  input  logic                in_stall_i,
  input  logic                out_valid_i,
  input  out_t                out_i,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [OffW-1:0]     cfg_wdata_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned MonthDays [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic [3:0]      char_pos;
  logic [3:0]      tens_digit;
  logic [6:0]      field_val [6];
  logic            err_flag;
  logic [OffW-1:0] winter_off;
  logic [OffW-1:0] summer_off;
  out_t            expected_epochs [$];
  int unsigned     mismatches = 0;
  int unsigned     waiting = 0;

  assign mismatch_count_o = mismatches;
  assign pending_o        = waiting;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  function automatic bit leap_year(input int unsigned y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Epoch of the held fields, less the offset that the suffix selects.
  function automatic out_t epoch_for(input logic [7:0] suffix);
    out_t        res;
    int unsigned yr;
    int unsigned mo;
    int unsigned days;
    int unsigned t;
    int unsigned q;
    yr   = 2000 + field_val[SlotYear];
    mo   = field_val[SlotMonth];
    days = 0;
    for (int unsigned y = 1970; y < yr; y++) begin
      days += leap_year(y) ? 366 : 365;
    end
    for (int unsigned m = 1; m < mo; m++) begin
      days += MonthDays[m-1];
      if (m == 2 && leap_year(yr)) begin
        days += 1;
      end
    end
    // day 0 wraps to one day before the first of the month
    days += field_val[SlotDay] - 1;
    t = days * 32'd86400 + field_val[SlotHour] * 32'd3600
      + field_val[SlotMinute] * 32'd60 + field_val[SlotSecond];
    if (suffix == CharWinter) begin
      t -= winter_off;
    end else if (suffix == CharSummer) begin
      t -= summer_off;
    end
    q = (t % 32'd3600) / 32'd900;
    res.epoch_seconds = t;
    res.quarter_index = q[1:0];
    res.quarter_start = t - (t % 32'd900);
    res.format_error  = 1'b0;
    return res;
  endfunction

  task automatic absorb_char(input in_t item);
    logic [7:0]  diff;
    logic [3:0]  d;
    int unsigned v;
    int unsigned slot;
    out_t        bad;
    if (item.start_req) begin
      char_pos = '0;
      err_flag = 1'b0;
    end
    if (char_pos < PosSuffix) begin
      diff = item.character - DigitLo;
      if (item.character >= DigitLo && item.character <= DigitHi) begin
        d = diff[3:0];
      end else begin
        d        = 4'd0;
        err_flag = 1'b1;
      end
      if (!char_pos[0]) begin
        tens_digit = d;
      end else begin
        v               = tens_digit * 10 + d;
        slot            = char_pos >> 1;
        field_val[slot] = v[6:0];
        if (slot == SlotMonth && (v < MonthMin || v > MonthMax)) begin
          err_flag = 1'b1;
        end
      end
      char_pos++;
    end else begin
      if (err_flag) begin
        bad              = '0;
        bad.format_error = 1'b1;
        expected_epochs.push_back(bad);
      end else begin
        expected_epochs.push_back(epoch_for(item.character));
      end
      char_pos = '0;
      err_flag = 1'b0;
    end
  endtask

  task automatic check_result(input out_t got);
    out_t want;
    if (expected_epochs.size() == 0) begin
      report_mismatch("result with nothing expected", got.epoch_seconds, 32'd0);
    end else begin
      want = expected_epochs.pop_front();
      if (got.epoch_seconds !== want.epoch_seconds) begin
        report_mismatch("epoch_seconds", got.epoch_seconds, want.epoch_seconds);
      end
      if (got.quarter_index !== want.quarter_index) begin
        report_mismatch("quarter_index", 32'(got.quarter_index), 32'(want.quarter_index));
      end
      if (got.quarter_start !== want.quarter_start) begin
        report_mismatch("quarter_start", got.quarter_start, want.quarter_start);
      end
      if (got.format_error !== want.format_error) begin
        report_mismatch("format_error", 32'(got.format_error), 32'(want.format_error));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      char_pos   = '0;
      tens_digit = '0;
      err_flag   = 1'b0;
      winter_off = WinterReset;
      summer_off = SummerReset;
      expected_epochs.delete();
      waiting    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgWinter: winter_off = cfg_wdata_i;
          CfgSummer: summer_off = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        check_result(out_i);
      end
      if (in_valid_i && !in_stall_i) begin
        absorb_char(in_i);
      end
      waiting = expected_epochs.size();
    end
  end

endmodule

// ===== sim/meter_time_string_to_epoch_tb.sv =====
// ----------------------------------------------------------------------------
// Meter time string to epoch: testbench top
// Feeds directed and random meter time strings with random idling on both
// channels, changes the offsets between phases and reports the verdict of
// the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module meter_time_string_to_epoch_tb;
  import mtse_pkg::*;

  localparam int unsigned ItemTarget    = 1200;
  localparam int unsigned NumPhases     = 6;
  localparam int unsigned DrainCycles   = 12;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned WatchdogLimit = 2000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  in_t                 in_i        = '0;
  logic                in_stall_o;
  logic                out_valid_o;
  out_t                out_o;
  logic                out_stall_i = 1'b0;
  logic                cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i   = CfgWinter;
  logic [OffW-1:0]     cfg_wdata_i = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned stuck      = 0;
  bit          gaps_on    = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned hold_left  = 0;
  logic [7:0]  text [13];

  meter_time_string_to_epoch dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_i        (in_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_o       (out_o),
    .out_stall_i (out_stall_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  meter_time_string_to_epoch_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_i             (in_i),
    .in_stall_i       (in_stall_o),
    .out_valid_i      (out_valid_o),
    .out_i            (out_o),
    .out_stall_i      (out_stall_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .pending_o        (pending)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Result side: random stalls, or a long hold-off when asked for one.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= gaps_on && ($urandom_range(99) < 26);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    wait (stuck >= WatchdogLimit);
    $display("meter_time_string_to_epoch_tb: done, errors");
    $finish;
  end

  // Offer one character; stall is sampled mid-cycle so the edge decides cleanly.
  task automatic send_char(input logic [7:0] ch, input logic st);
    bit taken;
    while (gaps_on && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    in_i.character    <= ch;
    in_i.start_req    <= st;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    items_sent++;
  endtask

  task automatic fill_text(input int unsigned yy, input int unsigned mo, input int unsigned dd,
                           input int unsigned hh, input int unsigned mi, input int unsigned ss,
                           input logic [7:0] suffix);
    int unsigned vals [6];
    vals = '{yy, mo, dd, hh, mi, ss};
    for (int i = 0; i < 6; i++) begin
      text[2*i]   = DigitLo + 8'(vals[i] / 10);
      text[2*i+1] = DigitLo + 8'(vals[i] % 10);
    end
    text[12] = suffix;
  endtask

  task automatic send_text(input logic st);
    for (int i = 0; i < 13; i++) begin
      send_char(text[i], (i == 0) ? st : 1'b0);
    end
  endtask

  // Let every result out, then write both offsets while the block is idle.
  task automatic drain_and_set(input logic [OffW-1:0] w, input logic [OffW-1:0] s);
    in_valid_i <= 1'b0;
    // read the count mid-cycle, after the checker has taken the last edge
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CfgWinter;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= CfgSummer;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [7:0] pick_suffix();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return CharWinter;
    if (r < 70) return CharSummer;
    return 8'($urandom_range(255));
  endfunction

  function automatic int unsigned pick_field(input int unsigned lo, input int unsigned hi);
    if ($urandom_range(99) < 85) return $urandom_range(hi, lo);
    return $urandom_range(99);
  endfunction

  initial begin
    logic [OffW-1:0] w_set [NumPhases];
    logic [OffW-1:0] s_set [NumPhases];
    int unsigned     phase_end;
    int unsigned     kind;
    int unsigned     n;
    int unsigned     mo;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all zero digits: month zero is an error, suffix W ignored
    fill_text(0, 0, 0, 0, 0, 0, CharWinter);
    send_text(1'b1);
    // largest digits, continuing without a start request
    fill_text(99, 12, 99, 99, 99, 99, CharSummer);
    send_text(1'b0);
    // drop a partial string, then a leap day
    fill_text(24, 2, 29, 23, 59, 59, CharWinter);
    for (int i = 0; i < 4; i++) send_char(text[i], i == 0);
    send_text(1'b1);
    // non-digit with the top bit set
    fill_text(0, 1, 1, 0, 0, 0, 8'h58);
    text[8] = 8'hFF;
    send_text(1'b1);
    // month thirteen
    fill_text(0, 13, 1, 0, 0, 0, CharWinter);
    send_text(1'b1);
    // day zero, other suffix
    fill_text(0, 1, 0, 0, 0, 0, 8'h00);
    send_text(1'b1);

    w_set = '{17'd0, 17'd86400, 17'h1FFFF, 17'($urandom_range(86400)), 17'd3600,
              17'($urandom_range(86400))};
    s_set = '{17'd0, 17'd86400, 17'd0, 17'($urandom_range(86400)), 17'd7200, 17'h1FFFF};

    for (int p = 0; p < NumPhases; p++) begin
      drain_and_set(w_set[p], s_set[p]);
      gaps_on = (p != 2);
      if (p == 1) hold_req = 1'b1;
      phase_end = items_sent + ItemTarget / NumPhases;
      while (items_sent < phase_end) begin
        kind = $urandom_range(99);
        fill_text($urandom_range(99), $urandom_range(12, 1), pick_field(1, 31),
                  pick_field(0, 23), pick_field(0, 59), pick_field(0, 59), pick_suffix());
        if (kind < 10) begin
          mo      = $urandom_range(1) ? 0 : $urandom_range(99, 13);
          text[2] = DigitLo + 8'(mo / 10);
          text[3] = DigitLo + 8'(mo % 10);
        end else if (kind < 18) begin
          text[$urandom_range(11)] = 8'($urandom_range(255));
        end
        if (kind >= 93) begin
          // noise, then realign with a start request
          n = $urandom_range(12, 1);
          for (int i = 0; i < n; i++) begin
            send_char(8'($urandom_range(255)), $urandom_range(3) == 0);
          end
          send_text(1'b1);
        end else begin
          send_text($urandom_range(99) < 70);
        end
      end
    end

    gaps_on = 1'b1;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("meter_time_string_to_epoch_tb: done, clean");
    end else begin
      $display("meter_time_string_to_epoch_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== meter_time_string_to_epoch.f =====
+incdir+hdl
hdl/mtse_pkg.sv
hdl/mtse_parse.sv
hdl/mtse_calc.sv
hdl/mtse_quart.sv
hdl/meter_time_string_to_epoch.sv
hdl/mtse_checker.sv
sim/meter_time_string_to_epoch_checker.sv
sim/meter_time_string_to_epoch_tb.sv
